/* rtl/core/dfs_maze_carver_defines.svh */
// Assertion macros used by the maze carver datapath.
`ifndef DFS_MAZE_CARVER_DEFINES_SVH
`define DFS_MAZE_CARVER_DEFINES_SVH

// Plain property, checked at every rising clock edge outside reset.
`define DMC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication, checked in the same cycle.
`define DMC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/dmc_pkg.sv */
// Shared constants and controller/datapath interface types of the maze carver.
package dmc_pkg;

  localparam int GRID_WIDTH_DEF  = 16;
  localparam int GRID_HEIGHT_DEF = 16;

  localparam logic [1:0] OP_STEP    = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic CFG_START_X = 1'b0;
  localparam logic CFG_START_Y = 1'b1;

  typedef struct packed {
    logic latch;     // input transfer: capture payload
    logic clr_wr;    // clearing pass write
    logic init;      // build start state
    logic stk_rd;    // read stack top
    logic top_cap;   // load current cell from stack read
    logic probe_rd;  // read visited bit of neighbour
    logic probe_cap; // capture open bit
    logic pop;
    logic pick;      // choose carve direction
    logic carve;
    logic wall_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic clr_last;
    logic pdir_last;
    logic open_any;
    logic second;
    logic sp_one;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/dmc_ctrl.sv */
// Sequencer of the maze carver: steps the datapath through each operation.
module dmc_ctrl
  import dmc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_INIT  = 11'b00000000010,
    S_IDLE  = 11'b00000000100,
    S_CHECK = 11'b00000001000,
    S_TOP   = 11'b00000010000,
    S_PROBE = 11'b00000100000,
    S_PCAP  = 11'b00001000000,
    S_EVAL  = 11'b00010000000,
    S_CARVE = 11'b00100000000,
    S_RDW   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   reply_q, reply_d;

  always_comb begin
    state_d    = state_q;
    reply_d    = reply_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = S_INIT;
      end
      S_INIT: begin
        cmd_o.init = 1'b1;
        reply_d    = 1'b0;
        state_d    = reply_q ? S_RDW : S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (in_op_i == OP_RESTART) begin
            state_d = S_CLEAR;
            reply_d = 1'b1;
          end else if (in_op_i == OP_STEP) begin
            state_d = S_CHECK;
          end else begin
            state_d = S_RDW;
          end
        end
      end
      S_CHECK: begin
        if (sts_i.done) begin
          state_d = S_RDW;
        end else begin
          cmd_o.stk_rd = 1'b1;
          state_d      = S_TOP;
        end
      end
      S_TOP: begin
        cmd_o.top_cap = 1'b1;
        state_d       = S_PROBE;
      end
      S_PROBE: begin
        cmd_o.probe_rd = 1'b1;
        state_d        = S_PCAP;
      end
      S_PCAP: begin
        cmd_o.probe_cap = 1'b1;
        state_d         = sts_i.pdir_last ? S_EVAL : S_PROBE;
      end
      S_EVAL: begin
        if (sts_i.open_any) begin
          cmd_o.pick = 1'b1;
          state_d    = S_CARVE;
        end else begin
          cmd_o.pop = 1'b1;
          // second pop, or stack now empty: finished
          state_d   = (sts_i.second || sts_i.sp_one) ? S_RDW : S_CHECK;
        end
      end
      S_CARVE: begin
        cmd_o.carve = 1'b1;
        state_d     = S_RDW;
      end
      S_RDW: begin
        cmd_o.wall_rd = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      reply_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reply_q <= reply_d;
    end
  end

endmodule

/* rtl/core/dmc_dp.sv */
// Datapath of the maze carver: maps, stack, counters and result register.
`include "dfs_maze_carver_defines.svh"
module dmc_dp
  import dmc_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [7:0] in_rand_word_i,
  input  logic [3:0] in_read_x_i,
  input  logic [3:0] in_read_y_i,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [3:0] out_wall_bits_o,
  output logic [3:0] out_current_x_o,
  output logic [3:0] out_current_y_o,
  output logic       out_carved_o,
  output logic [1:0] out_carve_dir_o,
  output logic [1:0] out_pops_o,
  output logic       out_done_res_o,
  output logic [8:0] out_stack_depth_o
);

  localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW     = $clog2(NCELLS);
  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_HEIGHT);
  localparam int SW     = AW + 1;
  localparam int EW     = XW + YW;
  localparam logic [SW-1:0] NC     = SW'(NCELLS);
  localparam logic [XW-1:0] X_LAST = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(GRID_HEIGHT - 1);
  localparam logic [AW-1:0] A_LAST = AW'(NCELLS - 1);

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(y) * AW'(GRID_WIDTH) + AW'(x);
  endfunction

  logic [3:0]    start_x_q, start_y_q;
  logic [XW-1:0] sx, cur_x_q, nx;
  logic [YW-1:0] sy, cur_y_q, ny;
  logic [AW-1:0] start_addr, cur_addr, naddr, clr_q, rd_addr_q;
  logic [SW-1:0] sp_q, vt_q, spm1;
  logic [1:0]    dsel, dir_q, pdir_q, opp, pk, sel;
  logic [3:0]    open_q, wall_rd_q;
  logic [2:0]    pops_q, kcnt, seen;
  logic [9:0]    prod;
  logic [7:0]    rnd_q;
  logic          inb, vis_rd_q, rd_in_q, carved_q, found, out_valid_q;
  logic [EW-1:0] stk_rd_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= 4'd0;
      start_y_q <= 4'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_START_X) start_x_q <= cfg_data_i;
      if (cfg_idx_i == CFG_START_Y) start_y_q <= cfg_data_i;
    end
  end

  // start coordinates saturate to the last column / row
  assign sx = (9'(start_x_q) >= 9'(GRID_WIDTH))  ? X_LAST : XW'(start_x_q);
  assign sy = (9'(start_y_q) >= 9'(GRID_HEIGHT)) ? Y_LAST : YW'(start_y_q);
  assign start_addr = cell_addr(sx, sy);
  assign cur_addr   = cell_addr(cur_x_q, cur_y_q);
  assign spm1       = sp_q - SW'(1);
  assign opp        = dir_q + 2'd2;

  // neighbour of the current cell
  assign dsel = cmd_i.carve ? dir_q : pdir_q;
  always_comb begin
    nx  = cur_x_q;
    ny  = cur_y_q;
    inb = 1'b0;
    case (dsel)
      2'd0: begin inb = (cur_y_q != '0);     ny = cur_y_q - YW'(1); end
      2'd1: begin inb = (cur_x_q != X_LAST); nx = cur_x_q + XW'(1); end
      2'd2: begin inb = (cur_y_q != Y_LAST); ny = cur_y_q + YW'(1); end
      default: begin inb = (cur_x_q != '0);  nx = cur_x_q - XW'(1); end
    endcase
  end
  assign naddr = cell_addr(nx, ny);

  // pick among open neighbours in order up, right, down, left
  always_comb begin
    kcnt  = 3'($countones(open_q));
    prod  = 10'(rnd_q) * 10'(kcnt);
    pk    = prod[9:8];
    seen  = 3'd0;
    sel   = 2'd0;
    found = 1'b0;
    for (int d = 0; d < 4; d++) begin
      if (open_q[d]) begin
        if (!found && seen == {1'b0, pk}) begin
          sel   = 2'(d);
          found = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  // visited map
  logic vis_mem [NCELLS];
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) vis_mem[clr_q] <= (clr_q == start_addr);
    else if (cmd_i.carve) vis_mem[naddr] <= 1'b1;
    if (cmd_i.probe_rd) vis_rd_q <= vis_mem[naddr];
  end

  // wall map: one plane per wall so both sides of a passage go down together
  for (genvar p = 0; p < 4; p++) begin : g_plane
    logic pl_mem [NCELLS];
    always_ff @(posedge clk_i) begin
      if (cmd_i.clr_wr) begin
        pl_mem[clr_q] <= 1'b1;
      end else if (cmd_i.carve && dir_q == 2'(p)) begin
        pl_mem[cur_addr] <= 1'b0;
      end else if (cmd_i.carve && opp == 2'(p)) begin
        pl_mem[naddr] <= 1'b0;
      end
      if (cmd_i.wall_rd) wall_rd_q[p] <= pl_mem[rd_addr_q];
    end
  end

  // cell stack
  logic [EW-1:0] stk_mem [NCELLS];
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) stk_mem[0] <= {sy, sx};
    else if (cmd_i.carve && sp_q < NC) stk_mem[sp_q[AW-1:0]] <= {ny, nx};
    if (cmd_i.stk_rd) stk_rd_q <= stk_mem[spm1[AW-1:0]];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      sp_q        <= '0;
      vt_q        <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      pdir_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= (clr_q == A_LAST) ? '0 : clr_q + AW'(1);
      if (cmd_i.init) begin
        sp_q    <= SW'(1);
        vt_q    <= SW'(1);
        cur_x_q <= sx;
        cur_y_q <= sy;
      end
      if (cmd_i.top_cap) {cur_y_q, cur_x_q} <= stk_rd_q;
      if (cmd_i.latch) pdir_q <= 2'd0;
      else if (cmd_i.probe_cap) pdir_q <= pdir_q + 2'd1;
      if (cmd_i.pop) sp_q <= spm1;
      if (cmd_i.carve) begin
        vt_q <= vt_q + SW'(1);
        if (sp_q < NC) sp_q <= sp_q + SW'(1);
      end
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // per-operation payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      rnd_q     <= in_rand_word_i;
      rd_in_q   <= (9'(in_read_x_i) < 9'(GRID_WIDTH)) && (9'(in_read_y_i) < 9'(GRID_HEIGHT));
      rd_addr_q <= cell_addr(XW'(in_read_x_i), YW'(in_read_y_i));
      pops_q    <= 3'd0;
      carved_q  <= 1'b0;
      dir_q     <= 2'd0;
    end
    if (cmd_i.probe_cap) open_q[pdir_q] <= inb && !vis_rd_q;
    if (cmd_i.pick) dir_q <= sel;
    if (cmd_i.pop) pops_q <= pops_q + 3'd1;
    if (cmd_i.carve) carved_q <= 1'b1;
    if (cmd_i.out_load) begin
      out_wall_bits_o   <= rd_in_q ? wall_rd_q : 4'd0;
      out_current_x_o   <= 4'(cur_x_q);
      out_current_y_o   <= 4'(cur_y_q);
      out_carved_o      <= carved_q;
      out_carve_dir_o   <= dir_q;
      out_pops_o        <= pops_q[1:0];
      out_done_res_o    <= sts_o.done;
      out_stack_depth_o <= 9'(sp_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.done      = (vt_q >= NC) || (sp_q == '0);
  assign sts_o.clr_last  = (clr_q == A_LAST);
  assign sts_o.pdir_last = (pdir_q == 2'd3);
  assign sts_o.open_any  = |open_q;
  assign sts_o.second    = (pops_q != 3'd0);
  assign sts_o.sp_one    = (sp_q == SW'(1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  `DMC_ASSERT(a_counts_range, (sp_q <= NC) && (vt_q <= NC), "stack or visited count overflow")
  `DMC_ASSERT_IMP(a_carve_open, cmd_i.carve, open_q[dir_q] && inb, "carve into closed cell")
  `DMC_ASSERT_IMP(a_no_overwrite, cmd_i.out_load, !out_valid_q || out_ready_i,
                  "result overwritten before transfer")

endmodule

/* rtl/core/dfs_maze_carver.sv */
// Step: reads the stack top, probes its four neighbors with one visited-map read each, then
// carves or pops; after one pop a second top is tried unless the stack ran empty, and once
// finished the step goes straight to the result. Read returns the walls of one cell.
// Restart clears the maps and builds the start state again. One operation at a time; the
// next transfer is taken in the cycle after the result is loaded.
// Reset: async active low, then a clearing pass over every cell, with no input taken.
module dfs_maze_carver
  import dmc_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_op_i,
  input  logic [7:0] in_rand_word_i,
  input  logic [3:0] in_read_x_i,
  input  logic [3:0] in_read_y_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] out_wall_bits_o,
  output logic [3:0] out_current_x_o,
  output logic [3:0] out_current_y_o,
  output logic       out_carved_o,
  output logic [1:0] out_carve_dir_o,
  output logic [1:0] out_pops_o,
  output logic       out_done_res_o,
  output logic [8:0] out_stack_depth_o
);

  cmd_t cmd;
  sts_t sts;

  dmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_op_i    (in_op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dmc_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_rand_word_i    (in_rand_word_i),
    .in_read_x_i       (in_read_x_i),
    .in_read_y_i       (in_read_y_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .out_wall_bits_o   (out_wall_bits_o),
    .out_current_x_o   (out_current_x_o),
    .out_current_y_o   (out_current_y_o),
    .out_carved_o      (out_carved_o),
    .out_carve_dir_o   (out_carve_dir_o),
    .out_pops_o        (out_pops_o),
    .out_done_res_o    (out_done_res_o),
    .out_stack_depth_o (out_stack_depth_o)
  );

endmodule
